// ===== src/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg
// Shared widths, register indexes and reset values for the modexp block.
// ----------------------------------------------------------------------------
`default_nettype none

package rme_pkg;

  localparam int WIDTH     = 16;
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int CFG_IDX_W = 2;

  typedef logic [WIDTH-1:0]     word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_MODULUS  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_PUB_EXP  = cfg_idx_t'(1);
  localparam cfg_idx_t REG_PRIV_EXP = cfg_idx_t'(2);

  localparam word_t MODULUS_RST  = word_t'(2);
  localparam word_t PUB_EXP_RST  = word_t'(3);
  localparam word_t PRIV_EXP_RST = word_t'(1);

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mm_res_t;

endpackage

`default_nettype wire

// ===== src/rsa_modular_exponentiation.sv =====
// ----------------------------------------------------------------------------
// rsa_modular_exponentiation
// value^exp mod n by right-to-left square and multiply, two bit-serial
// modular multipliers working side by side.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tdata = value[15:0], tuser = req_type
//  m_axis    out  tdata = result[15:0]
//  cfg       in   index 0 modulus, 1 pub_exp, 2 priv_exp
//
//  One item at a time: the base is first reduced mod n, then a multiply
//  and a square run side by side for each exponent bit up to the highest
//  one, the product kept where the bit is set. Modulus zero goes straight
//  to the result. A finished result sits in the output register; the next
//  item is taken meanwhile. Synchronous reset restores the register reset
//  values.
// ----------------------------------------------------------------------------
`default_nettype none

module rsa_modular_exponentiation
  import rme_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_axis_tvalid,
  output logic          s_axis_tready,
  input  wire word_t    s_axis_tdata,   // [15:0] value
  input  wire logic     s_axis_tuser,   // [0] req_type
  output logic          m_axis_tvalid,
  input  wire logic     m_axis_tready,
  output word_t         m_axis_tdata,   // [15:0] result
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire cfg_idx_t cfg_index,
  input  wire word_t    cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LAUNCH,
    S_MUL,
    S_DONE
  } state_t;

  state_t  state;
  word_t   modulus;
  word_t   pub_exp;
  word_t   priv_exp;
  word_t   m_reg;
  word_t   exp_sh;
  word_t   acc;
  word_t   base;
  logic    red;
  mm_res_t res0;
  mm_res_t res1;
  logic    start0;
  logic    start1;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign start0        = (state == S_LAUNCH) && (red || (exp_sh != '0));
  assign start1        = (state == S_LAUNCH) && !red && (exp_sh != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= MODULUS_RST;
      pub_exp  <= PUB_EXP_RST;
      priv_exp <= PRIV_EXP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODULUS:  modulus  <= cfg_data;
        REG_PUB_EXP:  pub_exp  <= cfg_data;
        REG_PRIV_EXP: priv_exp <= cfg_data;
        default: ;
      endcase
    end
  end

  rme_mulmod u_mul_acc (
    .clk   (clk),
    .rst   (rst),
    .start (start0),
    .a     (base),
    .b     (acc),
    .m     (m_reg),
    .res   (res0)
  );

  rme_mulmod u_mul_sq (
    .clk   (clk),
    .rst   (rst),
    .start (start1),
    .a     (base),
    .b     (base),
    .m     (m_reg),
    .res   (res1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      red           <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            base   <= s_axis_tdata;
            m_reg  <= modulus;
            exp_sh <= (s_axis_tuser == REQ_DECRYPT) ? priv_exp : pub_exp;
            red    <= 1'b1;
            if (modulus == '0) begin
              acc   <= '0;
              state <= S_DONE;
            end else begin
              acc   <= word_t'(1);
              state <= S_LAUNCH;
            end
          end
        end
        S_LAUNCH: begin
          if (red || (exp_sh != '0)) begin
            state <= S_MUL;
          end else begin
            state <= S_DONE;
          end
        end
        S_MUL: begin
          if (res0.done) begin
            if (red) begin
              base <= res0.prod;
              acc  <= (m_reg == word_t'(1)) ? '0 : word_t'(1);
              red  <= 1'b0;
            end else begin
              if (exp_sh[0]) begin
                acc <= res0.prod;
              end
              base   <= res1.prod;
              exp_sh <= exp_sh >> 1;
            end
            state <= S_LAUNCH;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= acc;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_units_in_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && !red) |-> (res0.done == res1.done))
    else $error("multipliers out of step");

  a_operands_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_LAUNCH && !red) |-> (acc < m_reg && base < m_reg))
    else $error("operand not reduced");

  a_no_start_while_busy: assert property (@(posedge clk) disable iff (rst)
    start0 |=> !start0)
    else $error("back to back multiplier start");

endmodule

`default_nettype wire

// ===== src/rme_mulmod.sv =====
// ----------------------------------------------------------------------------
// rme_mulmod
// Bit-serial modular multiplier: a * b mod m, one bit of a per cycle, MSB
// first. Needs b < m (or m = 1); res.done marks the result as ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rme_mulmod
  import rme_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire word_t   a,
  input  wire word_t   b,
  input  wire word_t   m,
  output mm_res_t      res
);

  localparam int TW = WIDTH + 2;

  logic             run;
  logic [CNT_W-1:0] cnt;
  word_t            a_sh;
  word_t            b_reg;
  word_t            m_reg;
  word_t            r;
  logic             done;

  logic [TW-1:0] t;
  logic [TW-1:0] m1;
  logic [TW-1:0] m2;
  word_t         r_next;

  always_comb begin
    m1 = TW'(m_reg);
    m2 = TW'({m_reg, 1'b0});
    t  = TW'({r, 1'b0}) + (a_sh[WIDTH-1] ? TW'(b_reg) : '0);
    if (t >= m2) begin
      r_next = word_t'(t - m2);
    end else if (t >= m1) begin
      r_next = word_t'(t - m1);
    end else begin
      r_next = word_t'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= '0;
        a_sh  <= a;
        b_reg <= b;
        m_reg <= m;
        r     <= '0;
      end else if (run) begin
        r    <= r_next;
        a_sh <= {a_sh[WIDTH-2:0], 1'b0};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(WIDTH - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.prod = r;

endmodule

`default_nettype wire
